// ===== rtl/iofr_pkg.sv =====
package iofr_pkg;

    localparam int SLOTS     = 16;
    localparam int TAG_BITS  = 16;
    localparam int SLOT_BITS = $clog2(SLOTS);

    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [TAG_BITS-1:0]  t_tag;

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_WINDOW   = 2'd1,
        ST_OCCUPIED = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    load_err;
        t_status err_code;
        logic    insert;
        logic    release_head;
    } t_cmd;

    typedef struct packed {
        logic in_window;
        logic slot_busy;
        logic head_valid;
        logic out_taken;
        logic out_last;
    } t_stat;

endpackage

// ===== rtl/iofr_ctrl.sv =====
module iofr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  iofr_pkg::t_stat i_stat,
    output iofr_pkg::t_cmd  o_cmd,
    output logic            o_idle
);

    iofr_pkg::t_state r_state;
    iofr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iofr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.err_code = iofr_pkg::ST_WINDOW;
        unique case (r_state)
            iofr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = iofr_pkg::S_CHECK;
                end
            end
            iofr_pkg::S_CHECK: begin
                if (!i_stat.in_window) begin
                    o_cmd.load_err = 1'b1;
                    o_cmd.err_code = iofr_pkg::ST_WINDOW;
                    n_state = iofr_pkg::S_OUT;
                end else if (i_stat.slot_busy) begin
                    o_cmd.load_err = 1'b1;
                    o_cmd.err_code = iofr_pkg::ST_OCCUPIED;
                    n_state = iofr_pkg::S_OUT;
                end else begin
                    o_cmd.insert = 1'b1;
                    n_state = iofr_pkg::S_SCAN;
                end
            end
            iofr_pkg::S_SCAN: begin
                if (i_stat.head_valid) begin
                    o_cmd.release_head = 1'b1;
                    n_state = iofr_pkg::S_OUT;
                end else begin
                    n_state = iofr_pkg::S_IDLE;
                end
            end
            iofr_pkg::S_OUT: begin
                if (i_stat.out_taken) begin
                    n_state = i_stat.out_last ? iofr_pkg::S_IDLE : iofr_pkg::S_SCAN;
                end
            end
            default: begin
                n_state = iofr_pkg::S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == iofr_pkg::S_IDLE);

endmodule

// ===== rtl/iofr_datapath.sv =====
module iofr_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  iofr_pkg::t_cmd  i_cmd,
    output iofr_pkg::t_stat o_stat,
    input  logic [31:0]     i_frame_number,
    input  logic [15:0]     i_buffer_tag,
    input  logic [28:0]     i_byte_count,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [1:0]      o_status,
    output logic [31:0]     o_released_frame,
    output logic [15:0]     o_released_tag,
    output logic [28:0]     o_released_bytes,
    output logic [47:0]     o_total_bytes,
    output logic [31:0]     o_frames_done,
    output logic            o_last
);

    logic [31:0]          r_fr;
    iofr_pkg::t_tag       r_tag;
    logic [28:0]          r_bytes;
    logic [31:0]          r_next;
    logic [47:0]          r_total;
    logic [iofr_pkg::SLOTS-1:0] r_valid;
    iofr_pkg::t_tag       r_slot_tag   [iofr_pkg::SLOTS];
    logic [28:0]          r_slot_bytes [iofr_pkg::SLOTS];

    logic                 r_o_valid;
    iofr_pkg::t_status    r_o_status;
    logic [31:0]          r_o_frame;
    logic [15:0]          r_o_tag;
    logic [28:0]          r_o_bytes;
    logic [47:0]          r_o_total;
    logic [31:0]          r_o_done;
    logic                 r_o_last;

    logic [31:0]          gap;
    iofr_pkg::t_slot      idx;
    iofr_pkg::t_slot      head;
    iofr_pkg::t_slot      head_nxt;
    logic [47:0]          sum;
    logic                 out_taken;

    assign gap       = r_fr - r_next;
    assign idx       = r_fr[iofr_pkg::SLOT_BITS-1:0];
    assign head      = r_next[iofr_pkg::SLOT_BITS-1:0];
    assign head_nxt  = head + iofr_pkg::t_slot'(1);
    assign sum       = r_total + 48'(r_slot_bytes[head]);
    assign out_taken = r_o_valid && !i_out_stall;

    assign o_stat.in_window  = (gap < 32'(iofr_pkg::SLOTS));
    assign o_stat.slot_busy  = r_valid[idx];
    assign o_stat.head_valid = r_valid[head];
    assign o_stat.out_taken  = out_taken;
    assign o_stat.out_last   = r_o_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_fr    <= i_frame_number;
            r_tag   <= iofr_pkg::t_tag'(i_buffer_tag);
            r_bytes <= i_byte_count;
        end
        if (i_cmd.insert) begin
            r_slot_tag[idx]   <= r_tag;
            r_slot_bytes[idx] <= r_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_next    <= '0;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.insert) begin
                r_valid[idx] <= 1'b1;
            end
            if (i_cmd.release_head) begin
                r_valid[head] <= 1'b0;
                r_next        <= r_next + 32'd1;
                r_total       <= sum;
            end
            if (i_cmd.load_err || i_cmd.release_head) begin
                r_o_valid <= 1'b1;
            end else if (out_taken) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_o_status <= i_cmd.err_code;
            r_o_frame  <= r_fr;
            r_o_tag    <= 16'(r_tag);
            r_o_bytes  <= r_bytes;
            r_o_total  <= r_total;
            r_o_done   <= r_next;
            r_o_last   <= 1'b1;
        end else if (i_cmd.release_head) begin
            r_o_status <= iofr_pkg::ST_RELEASED;
            r_o_frame  <= r_next;
            r_o_tag    <= 16'(r_slot_tag[head]);
            r_o_bytes  <= r_slot_bytes[head];
            r_o_total  <= sum;
            r_o_done   <= r_next + 32'd1;
            r_o_last   <= !r_valid[head_nxt];
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_released_frame = r_o_frame;
    assign o_released_tag   = r_o_tag;
    assign o_released_bytes = r_o_bytes;
    assign o_total_bytes    = r_o_total;
    assign o_frames_done    = r_o_done;
    assign o_last           = r_o_last;

endmodule

// ===== rtl/in_order_frame_release.sv =====
// An error item is flagged from the CHECK state, which follows the capture of its input item, and is then registered.
// The first released item is loaded from the SCAN state, after its input item is captured and inserted in CHECK.
// After an item of a run is taken, the controller returns to SCAN to release the next one.
// The next input item is accepted in the cycle after the last item of a run is taken.
// A synchronous active-low reset empties all slots and clears the counters.
module in_order_frame_release (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_frame_number,
    input  logic [15:0] i_buffer_tag,
    input  logic [28:0] i_byte_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_released_frame,
    output logic [15:0] o_released_tag,
    output logic [28:0] o_released_bytes,
    output logic [47:0] o_total_bytes,
    output logic [31:0] o_frames_done,
    output logic        o_last
);

    iofr_pkg::t_cmd  cmd;
    iofr_pkg::t_stat stat;
    logic            idle;

    iofr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    iofr_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_frame_number   (i_frame_number),
        .i_buffer_tag     (i_buffer_tag),
        .i_byte_count     (i_byte_count),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_released_frame (o_released_frame),
        .o_released_tag   (o_released_tag),
        .o_released_bytes (o_released_bytes),
        .o_total_bytes    (o_total_bytes),
        .o_frames_done    (o_frames_done),
        .o_last           (o_last)
    );

    assign o_in_stall = !idle;

    a_idle_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("output item pending while ready for input");

    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> !o_in_stall)
        else $error("input not ready after last item of a run");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second input item taken before the first was handled");

    a_release_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == iofr_pkg::ST_RELEASED)
            |-> (o_frames_done == o_released_frame + 32'd1))
        else $error("released frame does not match frame count");

endmodule

// ===== dv/in_order_frame_release_test.sv =====
module in_order_frame_release_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        iofr_pkg::t_status status;
        logic [31:0]       frame;
        logic [15:0]       tag;
        logic [28:0]       nbytes;
        logic [47:0]       total;
        logic [31:0]       done;
        logic              last;
    } t_release;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_frame_number = '0;
    logic [15:0] i_buffer_tag = '0;
    logic [28:0] i_byte_count = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_released_frame;
    logic [15:0] o_released_tag;
    logic [28:0] o_released_bytes;
    logic [47:0] o_total_bytes;
    logic [31:0] o_frames_done;
    logic        o_last;

    // Mirror of the reorder state, updated when an item is accepted.
    logic           parked[iofr_pkg::SLOTS];
    iofr_pkg::t_tag parked_tag[iofr_pkg::SLOTS];
    logic [28:0]    parked_bytes[iofr_pkg::SLOTS];
    logic [31:0]    expected_frame;
    logic [47:0]    bytes_released;

    t_release expected_releases[$];

    int fail_count = 0;
    int cycle_count = 0;
    int in_gap_pct = 0;
    int out_stall_pct = 0;

    in_order_frame_release dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_frame_number   (i_frame_number),
        .i_buffer_tag     (i_buffer_tag),
        .i_byte_count     (i_byte_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_released_frame (o_released_frame),
        .o_released_tag   (o_released_tag),
        .o_released_bytes (o_released_bytes),
        .o_total_bytes    (o_total_bytes),
        .o_frames_done    (o_frames_done),
        .o_last           (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    function automatic void park_and_release(input logic [31:0] frame, input logic [15:0] tag,
                                             input logic [28:0] nbytes);
        logic [31:0] gap;
        int          idx;
        int          count;
        t_release    r;
        gap = frame - expected_frame;
        idx = frame % iofr_pkg::SLOTS;
        r = '{iofr_pkg::ST_WINDOW, frame, 16'(iofr_pkg::t_tag'(tag)), nbytes, bytes_released,
              expected_frame, 1'b1};
        if (gap >= iofr_pkg::SLOTS) begin
            expected_releases.push_back(r);
            return;
        end
        if (parked[idx]) begin
            r.status = iofr_pkg::ST_OCCUPIED;
            expected_releases.push_back(r);
            return;
        end
        parked[idx] = 1'b1;
        parked_tag[idx] = iofr_pkg::t_tag'(tag);
        parked_bytes[idx] = nbytes;
        count = 0;
        while (count < iofr_pkg::SLOTS && parked[expected_frame % iofr_pkg::SLOTS]) begin
            idx = expected_frame % iofr_pkg::SLOTS;
            parked[idx] = 1'b0;
            bytes_released = bytes_released + 48'(parked_bytes[idx]);
            r.status = iofr_pkg::ST_RELEASED;
            r.frame = expected_frame;
            r.tag = 16'(parked_tag[idx]);
            r.nbytes = parked_bytes[idx];
            r.total = bytes_released;
            r.done = expected_frame + 1;
            r.last = (count == iofr_pkg::SLOTS - 1)
                     || !parked[(expected_frame + 1) % iofr_pkg::SLOTS];
            expected_releases.push_back(r);
            expected_frame = expected_frame + 1;
            count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_release r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_releases.size() == 0) begin
                fail_count <= fail_count + 1;
                if (fail_count < 10) begin
                    $display("Unexpected item: frame %0d status %0d",
                             o_released_frame, o_status);
                end
            end else begin
                r = expected_releases.pop_front();
                if (o_status !== r.status || o_released_frame !== r.frame
                        || o_released_tag !== r.tag || o_released_bytes !== r.nbytes
                        || o_total_bytes !== r.total || o_frames_done !== r.done
                        || o_last !== r.last) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) begin
                        $display("Mismatch: expected st %0d fr %0d tag %h by %0d",
                                 r.status, r.frame, r.tag, r.nbytes);
                        $display("          expected tot %0d done %0d last %0d",
                                 r.total, r.done, r.last);
                        $display("          actual   st %0d fr %0d tag %h by %0d",
                                 o_status, o_released_frame, o_released_tag,
                                 o_released_bytes);
                        $display("          actual   tot %0d done %0d last %0d",
                                 o_total_bytes, o_frames_done, o_last);
                    end
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_frame(input logic [31:0] frame, input logic [15:0] tag,
                              input logic [28:0] nbytes);
        if ($urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < in_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_frame_number <= frame;
        i_buffer_tag <= tag;
        i_byte_count <= nbytes;
        do @(posedge i_clk); while (o_in_stall);
        park_and_release(frame, tag, nbytes);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_releases.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [28:0] any_bytes();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return 29'($urandom);
        endcase
    endfunction

    task automatic test_in_order();
        send_frame(0, 16'h0000, 29'h0);
        send_frame(1, 16'hFFFF, 29'h1FFF_FFFF);
    endtask

    task automatic test_window_errors();
        send_frame(expected_frame + iofr_pkg::SLOTS, 16'hA5A5, 29'h1555_5555);
        send_frame(32'hFFFF_FFFF, 16'hFFFF, 29'h1FFF_FFFF);
        send_frame(expected_frame - 1, 16'h0000, 29'h0);
        send_frame(32'h8000_0000, 16'h5A5A, 29'h0AAA_AAAA);
    endtask

    task automatic test_occupied_slot();
        send_frame(expected_frame + 3, 16'h1234, 29'd100);
        send_frame(expected_frame + 3, 16'h4321, 29'd200);
        send_frame(expected_frame + iofr_pkg::SLOTS - 1, 16'hFFFF, 29'h1FFF_FFFF);
        send_frame(expected_frame + iofr_pkg::SLOTS - 1, 16'h0000, 29'h0);
    endtask

    task automatic test_full_run();
        logic [31:0] base;
        base = expected_frame;
        for (int off = 1; off < iofr_pkg::SLOTS; off++) begin
            if (!parked[(base + off) % iofr_pkg::SLOTS]) begin
                send_frame(base + off, 16'($urandom), any_bytes());
            end
        end
        send_frame(base, 16'hFFFF, 29'h1FFF_FFFF);
    endtask

    task automatic test_random_traffic(input int items);
        int          sent;
        int          k;
        int          j;
        logic [31:0] tmp;
        logic [31:0] batch[$];
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(99) < 80) begin
                batch.delete();
                k = $urandom_range(1, iofr_pkg::SLOTS);
                for (int off = 0; off < k; off++) begin
                    if (!parked[(expected_frame + off) % iofr_pkg::SLOTS]) begin
                        batch.push_back(expected_frame + off);
                    end
                end
                for (int i = batch.size() - 1; i > 0; i--) begin
                    j = $urandom_range(i);
                    tmp = batch[i];
                    batch[i] = batch[j];
                    batch[j] = tmp;
                end
                if (batch.size() > 1 && $urandom_range(3) == 0) begin
                    batch.delete($urandom_range(batch.size() - 1));
                end
                foreach (batch[i]) begin
                    send_frame(batch[i], 16'($urandom), any_bytes());
                    sent++;
                end
            end else begin
                case ($urandom_range(3))
                    0: tmp = $urandom;
                    1: tmp = expected_frame - 1 - $urandom_range(200);
                    2: tmp = expected_frame + iofr_pkg::SLOTS + $urandom_range(3);
                    default: begin
                        tmp = expected_frame + iofr_pkg::SLOTS;
                        for (int off = 1; off < iofr_pkg::SLOTS; off++) begin
                            if (parked[(expected_frame + off) % iofr_pkg::SLOTS]) begin
                                tmp = expected_frame + off;
                            end
                        end
                    end
                endcase
                send_frame(tmp, 16'($urandom), any_bytes());
                sent++;
            end
        end
    endtask

    initial begin
        foreach (parked[i]) begin
            parked[i] = 1'b0;
        end
        expected_frame = '0;
        bytes_released = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_in_order();
        test_window_errors();
        test_occupied_slot();
        test_full_run();
        wait_for_results();

        in_gap_pct = 35;
        out_stall_pct = 82;
        test_random_traffic(170);
        wait_for_results();
        in_gap_pct = 82;
        out_stall_pct = 35;
        test_random_traffic(160);
        wait_for_results();
        in_gap_pct = 0;
        out_stall_pct = 0;
        test_random_traffic(170);

        wait_for_results();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && expected_releases.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
